[rtl/pmfca_pkg.sv]
// Package with the shared constants and types of the PM2.5 frame checker and averager.
`default_nettype none
package pmfca_pkg;

  localparam int AVG_COUNT_DEFAULT = 5;
  localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;

  localparam logic [7:0] HDR_B0 = 8'h16;
  localparam logic [7:0] HDR_B1 = 8'h11;
  localparam logic [7:0] HDR_B2 = 8'h0B;

  localparam logic [7:0] POS_HDR0 = 8'd0;
  localparam logic [7:0] POS_HDR1 = 8'd1;
  localparam logic [7:0] POS_HDR2 = 8'd2;
  localparam logic [7:0] POS_PM_HI = 8'd5;
  localparam logic [7:0] POS_PM_LO = 8'd6;
  localparam logic [7:0] MIN_HDR_BYTES = 8'd3;

  typedef struct packed {
    logic        hdr_ok;
    logic        sum_ok;
    logic        accepted;
    logic [15:0] sample;
  } frame_res_t;

endpackage
`default_nettype wire

[rtl/pm_sensor_frame_checker_averager.sv]
// Top level of the PM2.5 sensor frame checker and averager.
// Accepts one received byte per clock cycle when out_stall allows, with a
// sustained rate of one beat per cycle. Each byte passes an input register,
// the frame check stage, the group accumulation stage, the divide multiplier
// stage and the result register, in that order, before a frame result
// appears at the output. Bytes that are not the last of a frame produce
// no result beat. A result beat waiting at the output does not block input
// until the internal stages behind it are full.
`default_nettype none
module pm_sensor_frame_checker_averager #(
  parameter int AVG_COUNT = pmfca_pkg::AVG_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             header_ok,
  output logic             checksum_ok,
  output logic             frame_accepted,
  output logic [15:0]      pm25_sample,
  output logic [15:0]      avg_pm25,
  output logic             avg_valid
);
  import pmfca_pkg::*;

  logic       res_valid;
  frame_res_t res;
  logic       res_ready;

  pmfca_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  pmfca_avg #(
    .AVG_COUNT (AVG_COUNT)
  ) u_avg (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .header_ok      (header_ok),
    .checksum_ok    (checksum_ok),
    .frame_accepted (frame_accepted),
    .pm25_sample    (pm25_sample),
    .avg_pm25       (avg_pm25),
    .avg_valid      (avg_valid)
  );

endmodule
`default_nettype wire

[rtl/pmfca_frame.sv]
// Input register and per-frame header, checksum and PM2.5 capture logic.
`default_nettype none
module pmfca_frame (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                frame_end,
  output logic                     res_valid,
  output pmfca_pkg::frame_res_t    res,
  input  wire logic                res_ready
);
  import pmfca_pkg::*;

  logic       v0;
  logic [7:0] b0;
  logic       e0;
  logic       en0;
  logic       en1;
  logic       move0;

  logic [7:0]  byte_count;
  logic [7:0]  running_sum;
  logic        header_match;
  logic [15:0] pm_capture;

  logic [7:0]  byte_count_next;
  logic        header_match_next;
  logic [15:0] pm_capture_next;
  frame_res_t  res_next;

  assign en1      = !res_valid || res_ready;
  assign en0      = !v0 || en1;
  assign move0    = v0 && en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      b0 <= rx_byte;
      e0 <= frame_end;
    end
  end

  always_comb begin
    header_match_next = header_match;
    if (byte_count == POS_HDR0 && b0 != HDR_B0) header_match_next = 1'b0;
    if (byte_count == POS_HDR1 && b0 != HDR_B1) header_match_next = 1'b0;
    if (byte_count == POS_HDR2 && b0 != HDR_B2) header_match_next = 1'b0;
    pm_capture_next = pm_capture;
    if (byte_count == POS_PM_HI) pm_capture_next[15:8] = b0;
    if (byte_count == POS_PM_LO) pm_capture_next[7:0] = b0;
    byte_count_next = (byte_count < MAX_FRAME_BYTES) ? byte_count + 8'd1 : byte_count;

    res_next.hdr_ok   = header_match_next && (byte_count_next >= MIN_HDR_BYTES);
    res_next.sum_ok   = ((8'd0 - running_sum) == b0);
    res_next.accepted = res_next.hdr_ok && res_next.sum_ok;
    res_next.sample   = pm_capture_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_sum  <= '0;
      header_match <= 1'b1;
      pm_capture   <= '0;
    end else if (move0) begin
      if (e0) begin
        byte_count   <= '0;
        running_sum  <= '0;
        header_match <= 1'b1;
        pm_capture   <= '0;
      end else begin
        byte_count   <= byte_count_next;
        running_sum  <= running_sum + b0;
        header_match <= header_match_next;
        pm_capture   <= pm_capture_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en1) begin
      res_valid <= move0 && e0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

[rtl/pmfca_avg.sv]
// Sample grouping, divide by the group size and the result register.
`default_nettype none
module pmfca_avg #(
  parameter int AVG_COUNT = pmfca_pkg::AVG_COUNT_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_valid,
  input  wire pmfca_pkg::frame_res_t res,
  output logic                     res_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     header_ok,
  output logic                     checksum_ok,
  output logic                     frame_accepted,
  output logic [15:0]              pm25_sample,
  output logic [15:0]              avg_pm25,
  output logic                     avg_valid
);
  import pmfca_pkg::*;

  localparam int LOG_D  = $clog2(AVG_COUNT);
  localparam int TOT_W  = 16 + LOG_D;
  localparam int SHIFT  = TOT_W + LOG_D;
  localparam int POS_W  = (AVG_COUNT > 1) ? LOG_D : 1;
  localparam int PROD_W = TOT_W + SHIFT + 1;
  localparam longint unsigned MUL_L = ((64'd1 << SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
  localparam logic [SHIFT:0] MUL = MUL_L[SHIFT:0];
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_COUNT - 1);

  logic en2;
  logic en3;
  logic en_o;

  logic [POS_W-1:0] ring_pos;
  logic [TOT_W-1:0] group_acc;
  logic [TOT_W-1:0] total_next;
  logic             wrap_next;

  logic             v2;
  frame_res_t       res2;
  logic [TOT_W-1:0] total2;
  logic             wrap2;

  logic              v3;
  frame_res_t        res3;
  logic [PROD_W-1:0] prod3;
  logic              wrap3;

  logic [15:0] avg_store;
  logic        avg_flag;
  logic [15:0] avg_store_next;

  assign en_o      = !out_valid || !out_stall;
  assign en3       = !v3 || en_o;
  assign en2       = !v2 || en3;
  assign res_ready = en2;

  assign total_next = group_acc + TOT_W'(res.sample);
  assign wrap_next  = res.accepted && (ring_pos == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos  <= '0;
      group_acc <= '0;
    end else if (res_valid && en2 && res.accepted) begin
      if (ring_pos == POS_LAST) begin
        ring_pos  <= '0;
        group_acc <= '0;
      end else begin
        ring_pos  <= ring_pos + POS_W'(1);
        group_acc <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en2) v2 <= res_valid;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res2   <= res;
      total2 <= total_next;
      wrap2  <= wrap_next;
    end
    if (en3) begin
      res3  <= res2;
      prod3 <= PROD_W'(total2) * PROD_W'(MUL);
      wrap3 <= wrap2;
    end
  end

  assign avg_store_next = wrap3 ? prod3[SHIFT +: 16] : avg_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      avg_store <= '0;
      avg_flag  <= 1'b0;
    end else if (en_o) begin
      out_valid <= v3;
      if (v3) begin
        avg_store <= avg_store_next;
        avg_flag  <= avg_flag || wrap3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      header_ok      <= res3.hdr_ok;
      checksum_ok    <= res3.sum_ok;
      frame_accepted <= res3.accepted;
      pm25_sample    <= res3.sample;
      avg_pm25       <= avg_store_next;
      avg_valid      <= avg_flag || wrap3;
    end
  end

endmodule
`default_nettype wire

[bench/pm_frame_result_checker.sv]
// Checker that predicts and compares the frame reports of the PM2.5 frame checker and averager.
`timescale 1ns / 1ps
module pm_frame_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        header_ok,
  input  logic        checksum_ok,
  input  logic        frame_accepted,
  input  logic [15:0] pm25_sample,
  input  logic [15:0] avg_pm25,
  input  logic        avg_valid,
  output int          mismatch_count,
  output int          reports_due
);
  import pmfca_pkg::*;

  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic        hdr_ok;
    logic        sum_ok;
    logic        accepted;
    logic [15:0] sample;
    logic [15:0] average;
    logic        average_ok;
  } frame_report_t;

  frame_report_t expected_reports[$];

  logic [7:0]  frame_pos;
  logic [7:0]  frame_sum;
  logic        hdr_good;
  logic [15:0] pm_word;
  logic [15:0] pm_history[AVG_COUNT_DEFAULT];
  int          history_pos;
  logic [15:0] avg_latch;
  logic        avg_seen;
  int          failures;

  initial begin
    failures = 0;
    mismatch_count = 0;
    reports_due = 0;
  end

  task automatic clear_frame();
    frame_pos = 8'd0;
    frame_sum = 8'd0;
    hdr_good = 1'b1;
    pm_word = 16'd0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    frame_report_t rep;
    logic [31:0] total;
    if (frame_pos == POS_HDR0 && b != HDR_B0) hdr_good = 1'b0;
    if (frame_pos == POS_HDR1 && b != HDR_B1) hdr_good = 1'b0;
    if (frame_pos == POS_HDR2 && b != HDR_B2) hdr_good = 1'b0;
    if (frame_pos == POS_PM_HI) pm_word[15:8] = b;
    if (frame_pos == POS_PM_LO) pm_word[7:0] = b;
    if (frame_pos < MAX_FRAME_BYTES) frame_pos = frame_pos + 8'd1;
    if (!last) begin
      frame_sum = frame_sum + b;
    end else begin
      rep.hdr_ok = hdr_good && (frame_pos >= MIN_HDR_BYTES);
      rep.sum_ok = (b == (8'd0 - frame_sum));
      rep.accepted = rep.hdr_ok && rep.sum_ok;
      rep.sample = pm_word;
      if (rep.accepted) begin
        pm_history[history_pos] = pm_word;
        history_pos++;
        if (history_pos >= AVG_COUNT_DEFAULT) begin
          history_pos = 0;
          total = 32'd0;
          for (int i = 0; i < AVG_COUNT_DEFAULT; i++) total += pm_history[i];
          avg_latch = 16'(total / AVG_COUNT_DEFAULT);
          avg_seen = 1'b1;
        end
      end
      rep.average = avg_latch;
      rep.average_ok = avg_seen;
      expected_reports.push_back(rep);
      clear_frame();
    end
  endtask

  task automatic compare_report();
    frame_report_t exp_rep;
    if (expected_reports.size() == 0) begin
      failures++;
      if (failures <= MAX_SHOWN)
        $display("%0t: report beat with none expected: hdr=%b sum=%b acc=%b pm=%h avg=%h av=%b",
                 $time, header_ok, checksum_ok, frame_accepted, pm25_sample, avg_pm25,
                 avg_valid);
    end else begin
      exp_rep = expected_reports.pop_front();
      if (header_ok !== exp_rep.hdr_ok || checksum_ok !== exp_rep.sum_ok ||
          frame_accepted !== exp_rep.accepted || pm25_sample !== exp_rep.sample ||
          avg_pm25 !== exp_rep.average || avg_valid !== exp_rep.average_ok) begin
        failures++;
        if (failures <= MAX_SHOWN) begin
          $display("%0t: expected hdr=%b sum=%b acc=%b pm=%h avg=%h av=%b", $time,
                   exp_rep.hdr_ok, exp_rep.sum_ok, exp_rep.accepted, exp_rep.sample,
                   exp_rep.average, exp_rep.average_ok);
          $display("%0t: actual   hdr=%b sum=%b acc=%b pm=%h avg=%h av=%b", $time,
                   header_ok, checksum_ok, frame_accepted, pm25_sample, avg_pm25,
                   avg_valid);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      history_pos = 0;
      avg_latch = 16'd0;
      avg_seen = 1'b0;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) compare_report();
      if (in_valid && !in_stall) absorb_byte(rx_byte, frame_end);
    end
    mismatch_count <= failures;
    reports_due <= expected_reports.size();
  end

endmodule

[bench/testbench.sv]
// Top of the testbench: clock, reset, frame stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import pmfca_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES = 580;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        frame_end = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        header_ok;
  logic        checksum_ok;
  logic        frame_accepted;
  logic [15:0] pm25_sample;
  logic [15:0] avg_pm25;
  logic        avg_valid;

  int mismatch_count;
  int reports_due;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;

  always #6 clk = ~clk;

  pm_sensor_frame_checker_averager dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .header_ok(header_ok),
    .checksum_ok(checksum_ok),
    .frame_accepted(frame_accepted),
    .pm25_sample(pm25_sample),
    .avg_pm25(avg_pm25),
    .avg_valid(avg_valid)
  );

  pm_frame_result_checker report_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .header_ok(header_ok),
    .checksum_ok(checksum_ok),
    .frame_accepted(frame_accepted),
    .pm25_sample(pm25_sample),
    .avg_pm25(avg_pm25),
    .avg_valid(avg_valid),
    .mismatch_count(mismatch_count),
    .reports_due(reports_due)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit hdr_good, input logic [15:0] pm,
                            input bit sum_good);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] last;
    int bad_pos;
    for (int i = 0; i < len - 1; i++) begin
      case (i)
        0: body.push_back(HDR_B0);
        1: body.push_back(HDR_B1);
        2: body.push_back(HDR_B2);
        5: body.push_back(pm[15:8]);
        6: body.push_back(pm[7:0]);
        default: body.push_back(8'($urandom_range(255)));
      endcase
    end
    if (!hdr_good && len > 1) begin
      bad_pos = $urandom_range((len - 2 < 2) ? len - 2 : 2, 0);
      body[bad_pos] = body[bad_pos] ^ 8'($urandom_range(255, 1));
    end
    sum = 8'd0;
    foreach (body[i]) sum = sum + body[i];
    last = 8'd0 - sum;
    if (!sum_good) last = last ^ 8'($urandom_range(255, 1));
    foreach (body[i]) send_byte(body[i], 1'b0);
    send_byte(last, 1'b1);
  endtask

  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int byte_budget);
    int start;
    int pick;
    logic [15:0] pm;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      pick = $urandom_range(99);
      case ($urandom_range(7))
        0: pm = 16'hFFFF;
        1: pm = 16'h0000;
        default: pm = 16'($urandom_range(65535));
      endcase
      if (pick < 75) send_frame($urandom_range(20, 7), 1'b1, pm, 1'b1);
      else if (pick < 83) send_frame($urandom_range(20, 4), 1'b0, pm, $urandom_range(1));
      else if (pick < 90) send_frame($urandom_range(20, 7), 1'b1, pm, 1'b0);
      else if (pick < 95) send_frame($urandom_range(6, 1), 1'b1, pm, $urandom_range(1));
      else send_noise($urandom_range(30, 1));
      if ($urandom_range(19) == 0) wait_for_reports();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_frame(1, 1'b1, 16'h0000, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_frame(2, 1'b1, 16'h0000, 1'b1);
    send_frame(3, 1'b1, 16'h0000, 1'b1);
    send_frame(6, 1'b1, 16'hABCD, 1'b1);
    send_frame(7, 1'b1, 16'h5AA5, 1'b1);
    send_frame(20, 1'b0, 16'h1234, 1'b1);
    send_frame(20, 1'b1, 16'h1234, 1'b0);
    send_frame(20, 1'b0, 16'h4321, 1'b0);
    repeat (5) send_frame(20, 1'b1, 16'hFFFF, 1'b1);
    send_frame(270, 1'b1, 16'h0F0F, 1'b1);
    repeat (4) send_frame(20, 1'b1, 16'h0000, 1'b1);
    send_frame(12, 1'b1, 16'h0001, 1'b1);
    wait_for_reports();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      run_random_phase(RANDOM_BYTES / 4);
      wait_for_reports();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
